/* design/sfram_pkg.sv */
// Shared types, opcodes and the microcode program for the SPI FRAM master.
// No dependencies; used by sfram_seq, sfram_dp and spi_fram_transaction_master.
package sfram_pkg;

    // Device opcodes and status check
    localparam logic [7:0] OP_WREN     = 8'h06;
    localparam logic [7:0] OP_WRITE    = 8'h02;
    localparam logic [7:0] OP_READ     = 8'h03;
    localparam logic [7:0] OP_RDSR     = 8'h05;
    localparam logic [7:0] OP_SLEEP    = 8'hB9;
    localparam logic [7:0] STATUS_MASK = 8'h71;
    localparam logic [7:0] STATUS_CODE = 8'h40;

    // Request modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_PROBE  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        UOP_SEL_LOW,
        UOP_SEL_HIGH,
        UOP_SEND,
        UOP_RECV,
        UOP_XFER,
        UOP_JUMP,
        UOP_FIN_OPEN,
        UOP_FIN_CLOSE,
        UOP_FIN_NONE
    } uop_t;

    typedef enum logic [2:0] {
        SRC_WREN,
        SRC_WRITE,
        SRC_READ,
        SRC_RDSR,
        SRC_SLEEP,
        SRC_ADDR_HI,
        SRC_ADDR_LO
    } byte_src_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_OPEN,
        COND_PROBE,
        COND_UNUSED,
        COND_READ,
        COND_NOT_LAST,
        COND_NOT_OK
    } cond_t;

    typedef enum logic [1:0] {
        LAST_NEVER,
        LAST_ALWAYS,
        LAST_IF_MORE,
        LAST_IF_ABSENT
    } last_t;

    typedef struct packed {
        uop_t      op;
        byte_src_t src;
        cond_t     cond;
        last_t     lastc;
        logic      pres;
        pc_t       target;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        logic       fire;
        logic       emit;
        logic       last_bit;
        logic [2:0] bit_idx;
        uword_t     word;
    } step_t;

    // Datapath to sequencer
    typedef struct packed {
        logic is_open;
        logic probe;
        logic unused;
        logic rd;
        logic more;
        logic ok;
    } flags_t;

    typedef struct packed {
        logic       mosi;
        logic       select_n;
        logic       clock_pulse;
        logic [7:0] read_data;
        logic       read_valid;
        logic       present;
        logic       present_valid;
        logic       last_slot;
    } slot_t;

    // Program entry points
    localparam pc_t A_RD   = pc_t'(10);
    localparam pc_t A_ADDR = pc_t'(12);
    localparam pc_t A_DATA = pc_t'(14);
    localparam pc_t A_FINO = pc_t'(18);
    localparam pc_t A_PR   = pc_t'(19);
    localparam pc_t A_FINN = pc_t'(27);

    function automatic uword_t uw(uop_t op, byte_src_t src, cond_t cond, last_t lastc,
                                  logic pres, pc_t target);
        uword_t w;
        w.op     = op;
        w.src    = src;
        w.cond   = cond;
        w.lastc  = lastc;
        w.pres   = pres;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t ucode_rom(pc_t pc);
        uword_t w;
        case (pc)
            // dispatch
            pc_t'(0):  w = uw(UOP_JUMP, SRC_WREN, COND_OPEN, LAST_NEVER, 1'b0, A_DATA);
            pc_t'(1):  w = uw(UOP_JUMP, SRC_WREN, COND_PROBE, LAST_NEVER, 1'b0, A_PR);
            pc_t'(2):  w = uw(UOP_JUMP, SRC_WREN, COND_UNUSED, LAST_NEVER, 1'b0, A_FINN);
            pc_t'(3):  w = uw(UOP_JUMP, SRC_WREN, COND_READ, LAST_NEVER, 1'b0, A_RD);
            // write header: WREN, reselect, WRITE
            pc_t'(4):  w = uw(UOP_SEL_LOW, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(5):  w = uw(UOP_SEND, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(6):  w = uw(UOP_SEL_HIGH, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(7):  w = uw(UOP_SEL_LOW, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(8):  w = uw(UOP_SEND, SRC_WRITE, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(9):  w = uw(UOP_JUMP, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, A_ADDR);
            // read header
            pc_t'(10): w = uw(UOP_SEL_LOW, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(11): w = uw(UOP_SEND, SRC_READ, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(12): w = uw(UOP_SEND, SRC_ADDR_HI, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(13): w = uw(UOP_SEND, SRC_ADDR_LO, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            // data byte and close
            pc_t'(14): w = uw(UOP_XFER, SRC_WREN, COND_ALWAYS, LAST_IF_MORE, 1'b0, '0);
            pc_t'(15): w = uw(UOP_JUMP, SRC_WREN, COND_NOT_LAST, LAST_NEVER, 1'b0, A_FINO);
            pc_t'(16): w = uw(UOP_SEL_HIGH, SRC_WREN, COND_ALWAYS, LAST_ALWAYS, 1'b0, '0);
            pc_t'(17): w = uw(UOP_FIN_CLOSE, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(18): w = uw(UOP_FIN_OPEN, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            // probe: RDSR, status, optional SLEEP
            pc_t'(19): w = uw(UOP_SEL_LOW, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(20): w = uw(UOP_SEND, SRC_RDSR, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(21): w = uw(UOP_RECV, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(22): w = uw(UOP_SEL_HIGH, SRC_WREN, COND_ALWAYS, LAST_IF_ABSENT, 1'b1, '0);
            pc_t'(23): w = uw(UOP_JUMP, SRC_WREN, COND_NOT_OK, LAST_NEVER, 1'b0, A_FINN);
            pc_t'(24): w = uw(UOP_SEL_LOW, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(25): w = uw(UOP_SEND, SRC_SLEEP, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
            pc_t'(26): w = uw(UOP_SEL_HIGH, SRC_WREN, COND_ALWAYS, LAST_ALWAYS, 1'b0, '0);
            default:   w = uw(UOP_FIN_NONE, SRC_WREN, COND_ALWAYS, LAST_NEVER, 1'b0, '0);
        endcase
        return w;
    endfunction

endpackage

/* design/sfram_seq.sv */
// Microcode sequencer: program counter, bit counter and jump logic.
// Depends on sfram_pkg (program table and control word types).
module sfram_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sfram_pkg::flags_t flags,
    input  logic             emit_ok,
    output logic             busy,
    output sfram_pkg::step_t step
);
    import sfram_pkg::*;

    pc_t        pc_reg, pc_next;
    logic [2:0] bit_reg, bit_next;
    logic       busy_reg, busy_next;
    uword_t     word;
    logic       multi;
    logic       emits;
    logic       fire;
    logic       taken;

    always_comb
    begin
        word  = ucode_rom(pc_reg);
        multi = word.op inside {UOP_SEND, UOP_RECV, UOP_XFER};
        emits = multi || (word.op inside {UOP_SEL_LOW, UOP_SEL_HIGH});
        fire  = busy_reg && (!emits || emit_ok);
    end

    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:   taken = 1'b1;
            COND_OPEN:     taken = flags.is_open;
            COND_PROBE:    taken = flags.probe;
            COND_UNUSED:   taken = flags.unused;
            COND_READ:     taken = flags.rd;
            COND_NOT_LAST: taken = flags.more;
            COND_NOT_OK:   taken = !flags.ok;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
            bit_next  = '0;
        end
        else if (fire)
        begin
            case (word.op)
                UOP_SEND, UOP_RECV, UOP_XFER:
                begin
                    if (bit_reg == 3'd7)
                    begin
                        bit_next = '0;
                        pc_next  = pc_reg + pc_t'(1);
                    end
                    else
                    begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
                UOP_JUMP:
                begin
                    pc_next = taken ? word.target : pc_reg + pc_t'(1);
                end
                UOP_FIN_OPEN, UOP_FIN_CLOSE, UOP_FIN_NONE:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                    pc_next = pc_reg + pc_t'(1);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            bit_reg  <= bit_next;
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        busy          = busy_reg;
        step.fire     = fire;
        step.emit     = emits;
        step.last_bit = (bit_reg == 3'd7);
        step.bit_idx  = bit_reg;
        step.word     = word;
    end

    // a partly sent byte only exists inside a serial step of a running item
    a_bit_in_serial: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_reg != 3'd0) |-> (busy_reg && multi))
        else $error("bit counter running outside a serial step");

    // a new request never lands on a running program
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("request taken while sequencer busy");

    // a serial step never leaves before its eighth bit
    a_serial_eight: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && multi && !start && bit_reg != 3'd7) |=> ($stable(pc_reg)))
        else $error("serial step left early");

endmodule

/* design/sfram_dp.sv */
// Datapath: request latch, transaction state, bit selection and slot output register.
// Depends on sfram_pkg (types, opcodes, status constants).
module sfram_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       s_tdata,
    input  logic [2:0]        s_tuser,
    input  logic              s_tlast,
    input  sfram_pkg::step_t  step,
    input  logic              m_tready,
    output sfram_pkg::flags_t flags,
    output logic              emit_ok,
    output logic              m_tvalid,
    output logic [15:0]       m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);
    import sfram_pkg::*;

    logic [1:0]  mode_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [7:0]  miso_reg;
    logic        last_reg;
    logic        in_tx_reg, in_tx_next;
    logic        cur_mode_reg, cur_mode_next;
    slot_t       slot_reg, slot_next, slot_w;
    logic        out_valid_reg, out_valid_next;

    logic        eff_mode;
    logic        ok;
    logic [7:0]  src_byte;
    logic        tx_bit;
    logic        wd_bit;
    logic        final_bit;

    // latch the request
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg  <= s_tuser[1:0];
            addr_reg  <= s_tdata[15:0];
            wdata_reg <= s_tdata[23:16];
            miso_reg  <= s_tdata[31:24];
            last_reg  <= s_tlast;
        end
    end

    always_comb
    begin
        eff_mode      = in_tx_reg ? cur_mode_reg : mode_reg[0];
        ok            = (miso_reg & STATUS_MASK) == STATUS_CODE;
        flags.is_open = in_tx_reg;
        flags.probe   = (mode_reg == MODE_PROBE);
        flags.unused  = (mode_reg == MODE_UNUSED);
        flags.rd      = (mode_reg == MODE_READ);
        flags.more    = !last_reg;
        flags.ok      = ok;
    end

    always_comb
    begin
        case (step.word.src)
            SRC_WREN:    src_byte = OP_WREN;
            SRC_WRITE:   src_byte = OP_WRITE;
            SRC_READ:    src_byte = OP_READ;
            SRC_RDSR:    src_byte = OP_RDSR;
            SRC_SLEEP:   src_byte = OP_SLEEP;
            SRC_ADDR_HI: src_byte = addr_reg[15:8];
            SRC_ADDR_LO: src_byte = addr_reg[7:0];
            default:     src_byte = '0;
        endcase
        tx_bit = src_byte[3'd7 - step.bit_idx];
        wd_bit = wdata_reg[3'd7 - step.bit_idx];
    end

    // build the slot for the current step
    always_comb
    begin
        slot_w    = '0;
        final_bit = 1'b1;
        case (step.word.op)
            UOP_SEL_LOW:
            begin
                slot_w.select_n = 1'b0;
            end
            UOP_SEL_HIGH:
            begin
                slot_w.select_n = 1'b1;
                if (step.word.pres)
                begin
                    slot_w.present       = ok;
                    slot_w.present_valid = 1'b1;
                end
            end
            UOP_SEND:
            begin
                slot_w.clock_pulse = 1'b1;
                slot_w.mosi        = tx_bit;
                final_bit          = step.last_bit;
            end
            UOP_RECV:
            begin
                slot_w.clock_pulse = 1'b1;
                final_bit          = step.last_bit;
            end
            UOP_XFER:
            begin
                slot_w.clock_pulse = 1'b1;
                final_bit          = step.last_bit;
                if (!eff_mode)
                begin
                    slot_w.mosi = wd_bit;
                end
                else if (step.last_bit)
                begin
                    slot_w.read_data  = miso_reg;
                    slot_w.read_valid = 1'b1;
                end
            end
            default:
            begin
                slot_w = '0;
            end
        endcase
        case (step.word.lastc)
            LAST_NEVER:     slot_w.last_slot = 1'b0;
            LAST_ALWAYS:    slot_w.last_slot = final_bit;
            LAST_IF_MORE:   slot_w.last_slot = final_bit && !last_reg;
            LAST_IF_ABSENT: slot_w.last_slot = final_bit && !ok;
            default:        slot_w.last_slot = 1'b0;
        endcase
    end

    always_comb
    begin
        emit_ok        = !out_valid_reg || m_tready;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        if (step.fire && step.emit)
        begin
            slot_next      = slot_w;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        in_tx_next    = in_tx_reg;
        cur_mode_next = cur_mode_reg;
        if (step.fire)
        begin
            case (step.word.op)
                UOP_FIN_OPEN:
                begin
                    in_tx_next    = 1'b1;
                    cur_mode_next = eff_mode;
                end
                UOP_FIN_CLOSE:
                begin
                    in_tx_next = 1'b0;
                end
                default:
                begin
                    in_tx_next = in_tx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            in_tx_reg     <= 1'b0;
            cur_mode_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            in_tx_reg     <= in_tx_next;
            cur_mode_reg  <= cur_mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, slot_reg.present, slot_reg.read_data,
                       slot_reg.select_n, slot_reg.mosi};
    assign m_tuser  = {slot_reg.present_valid, slot_reg.read_valid, slot_reg.clock_pulse};
    assign m_tlast  = slot_reg.last_slot;

    a_sel_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !slot_reg.clock_pulse) |-> !slot_reg.mosi)
        else $error("data driven on a select slot");

    a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && slot_reg.read_valid) |-> (slot_reg.clock_pulse && !slot_reg.select_n))
        else $error("read byte reported off a clock slot");

    a_probe_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && slot_reg.present_valid) |-> (slot_reg.select_n && !in_tx_reg))
        else $error("probe result outside a deselect");

endmodule

/* design/spi_fram_transaction_master.sv */
// Top level of the SPI mode 0 FRAM transaction master.
// Depends on sfram_pkg, sfram_seq and sfram_dp.
//
// Usage:
//   Slave side (s_*) takes one byte-level request per transfer. The chip sees
//   it as a stream of pin-level slots on the master side (m_*): each slot is
//   either one serial clock pulse with the data-out bit, or a chip-select
//   change. m_tlast marks the final slot caused by a request.
//   A request is taken only while no earlier request is still being worked
//   through; the last slot of one request may still wait in the output
//   register while the next request is taken.
//   With no stall the program runs one step per cycle and one serial bit per
//   step. A probe sends SLEEP only when the chip is present; unused mode while
//   idle ends with no slots.
//   Slots leave through one output register, loaded when their step fires.
//   When the receiver stalls (m_tready low with a slot held) the program
//   holds on the current step; jumps and end steps still advance.
//   Reset: no transaction open, output empty.
module spi_fram_transaction_master (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[15:0], write_data[23:16], miso_byte[31:24]
    input  logic [2:0]  s_tuser,   // mode[1:0], first_byte[2]
    input  logic        s_tlast,   // last_byte
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // mosi[0], select_n[1], read_data[9:2], present[10], zero
    output logic [2:0]  m_tuser,   // clock_pulse[0], read_valid[1], present_valid[2]
    output logic        m_tlast    // last_slot
);
    import sfram_pkg::*;

    logic   busy;
    logic   start;
    logic   emit_ok;
    flags_t flags;
    step_t  step;

    // take a request only when the program has finished the previous one
    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;

    sfram_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .flags   (flags),
        .emit_ok (emit_ok),
        .busy    (busy),
        .step    (step)
    );

    sfram_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .step     (step),
        .m_tready (m_tready),
        .flags    (flags),
        .emit_ok  (emit_ok),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
